FILE: rtl/stesc_pkg.sv
// ----------------------------------------------------------------------------
// stesc_pkg
// Types and constants shared by the styled text escape parser modules.
// ----------------------------------------------------------------------------
package stesc_pkg;

  // Kind of escape sequence that is currently open.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FONT  = 2'd1;
  localparam logic [1:0] KIND_COLOR = 2'd2;
  localparam logic [1:0] KIND_SIZE  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 48;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_FONT    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_SIZE    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_COLOR   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE_MASK  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ESCAPE_CODES = 3'd4;

  // Configuration reset values.
  localparam logic [31:0] RST_BASE_FONT    = 32'd0;
  localparam logic [7:0]  RST_BASE_SIZE    = 8'd8;
  localparam logic [15:0] RST_BASE_COLOR   = 16'd0;
  localparam logic [2:0]  RST_ENABLE_MASK  = 3'd7;
  localparam logic [47:0] RST_ESCAPE_CODES = 48'h0605_0403_0201;

  // Bits of the enable mask.
  localparam int unsigned EN_FONT  = 0;
  localparam int unsigned EN_COLOR = 1;
  localparam int unsigned EN_SIZE  = 2;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } text_item_t;

  // One result item.
  typedef struct packed {
    logic        is_letter;
    logic [15:0] letter_count;
    logic [31:0] cur_font;
    logic [7:0]  cur_size;
    logic [15:0] cur_color;
    logic        overflow;
    logic        end_of_text;
  } result_item_t;

  // Per-item request to one style stack.
  typedef struct packed {
    logic push;
    logic pop;
    logic rebase;
  } stack_ctl_t;

endpackage

FILE: rtl/stesc_stack.sv
// ----------------------------------------------------------------------------
// stesc_stack
// One style stack. Entry 0 is the live base value; higher entries live in a
// memory. The top is cached in a register and the entry below it is read
// ahead every cycle, so a pop has its new top ready at once.
// ----------------------------------------------------------------------------
module stesc_stack #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  stesc_pkg::stack_ctl_t ctl,
  input  logic [WIDTH-1:0]    push_value,
  input  logic [WIDTH-1:0]    base_value,
  output logic [WIDTH-1:0]    top,
  output logic [WIDTH-1:0]    top_next,
  output logic                full
);

  localparam int unsigned IDX_BITS   = $clog2(DEPTH);
  localparam int unsigned DEPTH_BITS = $clog2(DEPTH + 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_TWO  = DEPTH_BITS'(2);
  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = DEPTH_BITS'(DEPTH);

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_BITS-1:0] depth;
  logic [DEPTH_BITS-1:0] depth_next;
  logic [DEPTH_BITS-1:0] rd_addr;
  logic [WIDTH-1:0]      top_reg;
  logic [WIDTH-1:0]      below;
  logic                  do_push;
  logic                  do_pop;

  // Current top and the effect of this item's request.
  always_comb begin
    full    = (depth == DEPTH_FULL);
    top     = (depth <= DEPTH_ONE) ? base_value : top_reg;
    do_push = ctl.push && !full;
    do_pop  = ctl.pop && (depth > DEPTH_ONE);
    priority if (do_push) begin
      top_next   = push_value;
      depth_next = depth + DEPTH_ONE;
    end else if (do_pop) begin
      top_next   = (depth > DEPTH_TWO) ? below : base_value;
      depth_next = depth - DEPTH_ONE;
    end else begin
      top_next   = top;
      depth_next = depth;
    end
    if (ctl.rebase) begin
      depth_next = DEPTH_ONE;
    end
    rd_addr = depth_next - DEPTH_TWO;
  end

  // Depth counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= DEPTH_ONE;
    end else begin
      depth <= depth_next;
    end
  end

  // Cached top entry.
  always_ff @(posedge clk) begin
    if (do_push) begin
      top_reg <= push_value;
    end else if (do_pop) begin
      top_reg <= below;
    end
  end

  // Stack memory: write at the push slot, read ahead the entry below the top.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[depth[IDX_BITS-1:0]] <= push_value;
    end
    below <= mem[rd_addr[IDX_BITS-1:0]];
  end

endmodule

FILE: rtl/styled_text_escape_parser_top.sv
// ----------------------------------------------------------------------------
// styled_text_escape_parser_top
// Parses in-band font, color and size escapes out of a text byte stream and
// reports, for every byte, the letter flag, letter count and current style.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on the item channel (item_valid, item_stall, item), one
//   per cycle; an item is taken at an edge where item_valid is high and
//   item_stall is low. Every item gives exactly one result item on the
//   result channel (result_valid, result_stall, result).
//   The result of an item is written at the edge at which it is taken, into
//   the output register, or the skid register while the output is stalled.
//   Throughput is one item per cycle while item_stall is low; a single decode
//   and stack update are done between the input port and the output register.
//   A skid register behind the output register lets one more item in while
//   a result is stalled; item_stall rises only when both hold results.
//   Configuration registers are written through cfg_valid, cfg_index and
//   cfg_data; cfg_ready is always high. The user is to make writes only while
//   idle; the block does not enforce it. Synchronous reset clears the output
//   buffers, escape state, letter count and stack depths, and loads the default
//   configuration. A result item with end_of_text set returns style to base.
// ----------------------------------------------------------------------------
module styled_text_escape_parser_top #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  stesc_pkg::text_item_t                 item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output stesc_pkg::result_item_t               result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [stesc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [stesc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam logic [2:0] NEED_FONT  = 3'd5;
  localparam logic [2:0] NEED_COLOR = 3'd2;
  localparam logic [2:0] NEED_SIZE  = 3'd1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [31:0]      base_font;
  logic [7:0]       base_size;
  logic [15:0]      base_color;
  logic [2:0]       enable_mask;
  logic [5:0][7:0]  escape_codes;

  // Parser state.
  logic [1:0]            kind;
  logic [2:0]            pos;
  logic [3:0][7:0]       esc_bytes;
  logic [COUNT_BITS-1:0] letters;

  logic [1:0]            kind_next;
  logic [2:0]            pos_next;
  logic [3:0][7:0]       esc_bytes_next;
  logic [COUNT_BITS-1:0] letters_next;

  // Decode signals.
  logic        accept;
  logic [7:0]  b;
  logic        fresh;
  logic        complete;
  logic [2:0]  pos_inc;
  logic [2:0]  need;
  logic        letter;
  logic [1:0]  fresh_kind;
  logic        pop_font;
  logic        pop_color;
  logic        pop_size;
  logic [31:0] font_id;
  logic [31:0] font_push_value;
  logic [15:0] color_push_value;

  stesc_pkg::stack_ctl_t font_ctl;
  stesc_pkg::stack_ctl_t color_ctl;
  stesc_pkg::stack_ctl_t size_ctl;

  logic [31:0] font_top;
  logic [31:0] font_top_next;
  logic        font_full;
  logic [15:0] color_top;
  logic [15:0] color_top_next;
  logic        color_full;
  logic [7:0]  size_top;
  logic [7:0]  size_top_next;
  logic        size_full;

  // Output buffering.
  stesc_pkg::result_item_t new_result;
  stesc_pkg::result_item_t skid;
  logic                    skid_valid;
  logic                    out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign b          = item.text_byte;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_font    <= stesc_pkg::RST_BASE_FONT;
      base_size    <= stesc_pkg::RST_BASE_SIZE;
      base_color   <= stesc_pkg::RST_BASE_COLOR;
      enable_mask  <= stesc_pkg::RST_ENABLE_MASK;
      escape_codes <= stesc_pkg::RST_ESCAPE_CODES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stesc_pkg::CFG_BASE_FONT:    base_font    <= cfg_data[31:0];
        stesc_pkg::CFG_BASE_SIZE:    base_size    <= cfg_data[7:0];
        stesc_pkg::CFG_BASE_COLOR:   base_color   <= cfg_data[15:0];
        stesc_pkg::CFG_ENABLE_MASK:  enable_mask  <= cfg_data[2:0];
        stesc_pkg::CFG_ESCAPE_CODES: escape_codes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Escape sequence tracking: continue an open escape or decode a fresh byte.
  always_comb begin
    unique case (kind)
      stesc_pkg::KIND_FONT:  need = NEED_FONT;
      stesc_pkg::KIND_COLOR: need = NEED_COLOR;
      default:               need = NEED_SIZE;
    endcase
    pos_inc  = pos + 3'd1;
    fresh    = (kind == stesc_pkg::KIND_NONE) || (b == 8'd0);
    complete = !fresh && (pos_inc >= need);

    // A fresh byte is matched against the codes, first match winning.
    fresh_kind = stesc_pkg::KIND_NONE;
    pop_font   = 1'b0;
    pop_color  = 1'b0;
    pop_size   = 1'b0;
    letter     = 1'b0;
    priority if (b == escape_codes[0]) begin
      fresh_kind = stesc_pkg::KIND_FONT;
    end else if (b == escape_codes[1]) begin
      fresh_kind = stesc_pkg::KIND_COLOR;
    end else if (b == escape_codes[2]) begin
      fresh_kind = stesc_pkg::KIND_SIZE;
    end else if (b == escape_codes[3]) begin
      pop_font = enable_mask[stesc_pkg::EN_FONT];
    end else if (b == escape_codes[4]) begin
      pop_color = enable_mask[stesc_pkg::EN_COLOR];
    end else if (b == escape_codes[5]) begin
      pop_size = enable_mask[stesc_pkg::EN_SIZE];
    end else begin
      letter = 1'b1;
    end
    if (!fresh) begin
      pop_font  = 1'b0;
      pop_color = 1'b0;
      pop_size  = 1'b0;
      letter    = 1'b0;
    end

    // Next escape state.
    esc_bytes_next = esc_bytes;
    priority if (fresh) begin
      kind_next      = fresh_kind;
      pos_next       = 3'd0;
      esc_bytes_next = '0;
    end else if (complete) begin
      kind_next      = stesc_pkg::KIND_NONE;
      pos_next       = 3'd0;
      esc_bytes_next = '0;
    end else begin
      kind_next                = kind;
      pos_next                 = pos_inc;
      esc_bytes_next[pos[1:0]] = b;
    end

    // Saturating letter count.
    letters_next = (letter && (letters != COUNT_MAX)) ? letters + COUNT_BITS'(1)
                                                      : letters;
  end

  // Push values. Each id byte has its low bit flipped unless its flag bit is set.
  always_comb begin
    font_id = {esc_bytes[1] ^ {7'd0, ~esc_bytes[0][0]},
               esc_bytes[2] ^ {7'd0, ~esc_bytes[0][1]},
               esc_bytes[3] ^ {7'd0, ~esc_bytes[0][2]},
               b            ^ {7'd0, ~esc_bytes[0][3]}};
    // A zero id repeats the current font.
    font_push_value  = (font_id == 32'd0) ? font_top : font_id;
    color_push_value = {esc_bytes[0], b};
  end

  // Stack requests for this item.
  always_comb begin
    font_ctl.push    = accept && complete && (kind == stesc_pkg::KIND_FONT)
                       && enable_mask[stesc_pkg::EN_FONT];
    font_ctl.pop     = accept && pop_font;
    font_ctl.rebase  = accept && item.last;
    color_ctl.push   = accept && complete && (kind == stesc_pkg::KIND_COLOR)
                       && enable_mask[stesc_pkg::EN_COLOR];
    color_ctl.pop    = accept && pop_color;
    color_ctl.rebase = accept && item.last;
    size_ctl.push    = accept && complete && (kind == stesc_pkg::KIND_SIZE)
                       && enable_mask[stesc_pkg::EN_SIZE];
    size_ctl.pop     = accept && pop_size;
    size_ctl.rebase  = accept && item.last;
  end

  stesc_stack #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_font_stack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (font_ctl),
    .push_value (font_push_value),
    .base_value (base_font),
    .top        (font_top),
    .top_next   (font_top_next),
    .full       (font_full)
  );

  stesc_stack #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_color_stack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (color_ctl),
    .push_value (color_push_value),
    .base_value (base_color),
    .top        (color_top),
    .top_next   (color_top_next),
    .full       (color_full)
  );

  stesc_stack #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_size_stack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (size_ctl),
    .push_value (b),
    .base_value (base_size),
    .top        (size_top),
    .top_next   (size_top_next),
    .full       (size_full)
  );

  // Parser state registers; the last byte returns everything to base.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind      <= stesc_pkg::KIND_NONE;
      pos       <= 3'd0;
      esc_bytes <= '0;
      letters   <= '0;
    end else if (accept) begin
      if (item.last) begin
        kind      <= stesc_pkg::KIND_NONE;
        pos       <= 3'd0;
        esc_bytes <= '0;
        letters   <= '0;
      end else begin
        kind      <= kind_next;
        pos       <= pos_next;
        esc_bytes <= esc_bytes_next;
        letters   <= letters_next;
      end
    end
  end

  // Result of this item.
  always_comb begin
    new_result.is_letter    = letter;
    new_result.letter_count = 16'(letters_next);
    new_result.cur_font     = font_top_next;
    new_result.cur_size     = size_top_next;
    new_result.cur_color    = color_top_next;
    new_result.overflow     = (font_ctl.push && font_full)
                              || (color_ctl.push && color_full)
                              || (size_ctl.push && size_full);
    new_result.end_of_text  = item.last;
  end

  // Output register with a skid register behind it.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= new_result;
      end
    end else if (accept) begin
      skid <= new_result;
    end
  end

endmodule
